@@ rtl/core/bsm_pkg.sv @@
// Shared types for the bounding sphere merge pipeline.
// No dependencies; imported by bsm_sqrt, bsm_div, the top level and the testbench.
`default_nettype none

package bsm_pkg;

  // Pipeline control that runs alongside every stage group.
  typedef struct packed {
    logic en;   // advance all stages this cycle
    logic vld;  // an item enters the unit this cycle
  } bsm_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/bsm_sqrt.sv @@
// Pipelined integer square root, one root bit resolved per stage (floor).
// Depends on bsm_pkg for the control struct.
`default_nettype none

module bsm_sqrt #(
  parameter int unsigned W      = 25,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bsm_pkg::bsm_ctl_t       ctl_i,
  input  logic [2*W-1:0]          rad_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    vld_o,
  output logic [W-1:0]            root_o,
  output logic [SIDE_W-1:0]       side_o
);
  import bsm_pkg::*;

  localparam int unsigned RW = W + 3;

  logic [RW-1:0]     rem_s  [W+1];
  logic [W-1:0]      root_s [W+1];
  logic [2*W-1:0]    rad_s  [W+1];
  logic [SIDE_W-1:0] side_s [W+1];
  logic [W:0]        v_s;

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad_i;
  assign side_s[0] = side_i;
  assign v_s[0]    = ctl_i.vld;

  for (genvar k = 0; k < W; k++) begin : g_stg
    logic [RW-1:0]     acc, trial, rem_d, rem_q;
    logic [W-1:0]      root_d, root_q;
    logic [2*W-1:0]    rad_q;
    logic [SIDE_W-1:0] side_q;
    logic              ge, v_q;

    always_comb begin
      acc    = {rem_s[k][RW-3:0], rad_s[k][2*W-1 -: 2]};
      trial  = RW'({root_s[k], 2'b01});
      ge     = (acc >= trial);
      rem_d  = ge ? (acc - trial) : acc;
      root_d = {root_s[k][W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else if (ctl_i.en) v_q <= v_s[k];
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        rad_q  <= rad_s[k] << 2;
        side_q <= side_s[k];
      end
    end

    assign rem_s[k+1]  = rem_q;
    assign root_s[k+1] = root_q;
    assign rad_s[k+1]  = rad_q;
    assign side_s[k+1] = side_q;
    assign v_s[k+1]    = v_q;
  end

  assign vld_o  = v_s[W];
  assign root_o = root_s[W];
  assign side_o = side_s[W];

endmodule

`default_nettype wire

@@ rtl/core/bsm_div.sv @@
// Pipelined restoring divider, three lanes over one shared divisor,
// one quotient bit per stage. Depends on bsm_pkg for the control struct.
`default_nettype none

module bsm_div #(
  parameter int unsigned QW     = 25,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bsm_pkg::bsm_ctl_t        ctl_i,
  input  logic [2:0][2*QW-1:0]     num_i,
  input  logic [QW-1:0]            den_i,
  input  logic [SIDE_W-1:0]        side_i,
  output logic                     vld_o,
  output logic [2:0][QW-1:0]       quo_o,
  output logic [SIDE_W-1:0]        side_o
);
  import bsm_pkg::*;

  localparam int unsigned NW = 2 * QW;

  logic [2:0][NW-1:0] rem_s  [QW+1];
  logic [2:0][QW-1:0] quo_s  [QW+1];
  logic [QW-1:0]      den_s  [QW+1];
  logic [SIDE_W-1:0]  side_s [QW+1];
  logic [QW:0]        v_s;

  assign rem_s[0]  = num_i;
  assign quo_s[0]  = '0;
  assign den_s[0]  = den_i;
  assign side_s[0] = side_i;
  assign v_s[0]    = ctl_i.vld;

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic [NW-1:0]      dsh;
    logic [2:0][NW-1:0] rem_d, rem_q;
    logic [2:0][QW-1:0] quo_d, quo_q;
    logic [QW-1:0]      den_q;
    logic [SIDE_W-1:0]  side_q;
    logic               v_q;

    // trial subtract of the divisor aligned to the current quotient bit
    always_comb begin
      dsh = NW'(den_s[k]) << (QW - 1 - k);
      for (int l = 0; l < 3; l++) begin
        if (rem_s[k][l] >= dsh) begin
          rem_d[l] = rem_s[k][l] - dsh;
          quo_d[l] = {quo_s[k][l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_s[k][l];
          quo_d[l] = {quo_s[k][l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else if (ctl_i.en) v_q <= v_s[k];
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        den_q  <= den_s[k];
        side_q <= side_s[k];
      end
    end

    assign rem_s[k+1]  = rem_q;
    assign quo_s[k+1]  = quo_q;
    assign den_s[k+1]  = den_q;
    assign side_s[k+1] = side_q;
    assign v_s[k+1]    = v_q;
  end

  assign vld_o  = v_s[QW];
  assign quo_o  = quo_s[QW];
  assign side_o = side_s[QW];

endmodule

`default_nettype wire

@@ rtl/core/bounding_sphere_merge_top.sv @@
// Top level of the bounding sphere merge pipeline.
// Depends on bsm_pkg, bsm_sqrt and bsm_div.
`default_nettype none

// Merges two spheres (signed fixed-point centers, unsigned radii) into the
// smallest sphere that encloses both, and reports the growth of the radius
// squared relative to sphere a, a strict overlap test and a saturation flag.
// When one sphere contains the other the larger is returned (b on a tie).
// The pipeline takes one transfer every cycle unless the output stalls, and returns
// results in order. It has three setup stages (offsets, squares, sum and
// compare), a COORD_BITS+1 stage square root, two stages for the radius and
// the step products, a COORD_BITS+1 stage divider for the center step, and
// the output register. All stages advance together; while a result sits in
// the output register under stall, the whole pipeline holds and in_stall_o
// is raised. There is no startup sequence: the block can take a transfer as
// soon as reset is released.
module bounding_sphere_merge_top #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [COORD_BITS-1:0] a_center_x_i,
  input  logic signed [COORD_BITS-1:0] a_center_y_i,
  input  logic signed [COORD_BITS-1:0] a_center_z_i,
  input  logic [COORD_BITS-2:0]        a_radius_i,
  input  logic signed [COORD_BITS-1:0] b_center_x_i,
  input  logic signed [COORD_BITS-1:0] b_center_y_i,
  input  logic signed [COORD_BITS-1:0] b_center_z_i,
  input  logic [COORD_BITS-2:0]        b_radius_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [COORD_BITS-1:0] merged_x_o,
  output logic signed [COORD_BITS-1:0] merged_y_o,
  output logic signed [COORD_BITS-1:0] merged_z_o,
  output logic [COORD_BITS-2:0]        merged_radius_o,
  output logic [2*COORD_BITS-3:0]      growth_o,
  output logic                        overlap_o,
  output logic                        saturated_o
);
  import bsm_pkg::*;

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned QW  = C + 1;       // offset magnitude, sqrt and quotient
  localparam int unsigned D2W = 2 * C + 2;   // squared distance
  localparam int unsigned RW  = C - 1;       // radius
  localparam int unsigned GW  = 2 * RW;      // growth

  // Payload that rides along the square root.
  typedef struct packed {
    logic [2:0][C-1:0] ca;
    logic [2:0][C:0]   off;
    logic [RW-1:0]     ra;
    logic [RW-1:0]     rb;
    logic              contain;
    logic              ovl;
  } root_side_t;

  // Payload that rides along the divider.
  typedef struct packed {
    logic [2:0][C-1:0] ca;
    logic [2:0][C:0]   off;
    logic [RW-1:0]     rout;
    logic [GW-1:0]     rout2;
    logic [GW-1:0]     ra2;
    logic              contain;
    logic              pick_a;
    logic              ovl;
    logic              sat;
  } div_side_t;

  localparam int unsigned RSW = $bits(root_side_t);
  localparam int unsigned DSW = $bits(div_side_t);

  logic en;
  logic out_valid_q;

  // Advance everything unless a finished result is held by the consumer.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------- stage 1
  // Offsets b - a, their magnitudes, radius difference and sum.
  logic                    s1_v_q;
  logic [2:0][C-1:0]       s1_ca_q;
  logic [2:0][C:0]         s1_off_q;
  logic [2:0][QW-1:0]      s1_mag_q;
  logic [RW-1:0]           s1_ra_q, s1_rb_q, s1_rdif_q;
  logic [C-1:0]            s1_rsum_q;

  logic [2:0][C-1:0]       in_a, in_b;
  logic [2:0][C:0]         s1_off_d;
  logic [2:0][QW-1:0]      s1_mag_d;

  assign in_a = {a_center_z_i, a_center_y_i, a_center_x_i};
  assign in_b = {b_center_z_i, b_center_y_i, b_center_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_off_d[i] = $signed({in_b[i][C-1], in_b[i]}) - $signed({in_a[i][C-1], in_a[i]});
      s1_mag_d[i] = s1_off_d[i][C] ? (QW'(0) - s1_off_d[i]) : s1_off_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ca_q   <= in_a;
      s1_off_q  <= s1_off_d;
      s1_mag_q  <= s1_mag_d;
      s1_ra_q   <= a_radius_i;
      s1_rb_q   <= b_radius_i;
      s1_rdif_q <= (a_radius_i > b_radius_i) ? (a_radius_i - b_radius_i)
                                             : (b_radius_i - a_radius_i);
      s1_rsum_q <= C'(a_radius_i) + C'(b_radius_i);
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Squares: one multiplier per axis plus the two radius terms.
  logic                    s2_v_q;
  logic [2:0][C-1:0]       s2_ca_q;
  logic [2:0][C:0]         s2_off_q;
  logic [2:0][D2W-1:0]     s2_sq_q;
  logic [RW-1:0]           s2_ra_q, s2_rb_q;
  logic [GW-1:0]           s2_rd2_q;
  logic [2*C-1:0]          s2_rs2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s2_sq_q[i] <= s1_mag_q[i] * s1_mag_q[i];
      s2_ca_q  <= s1_ca_q;
      s2_off_q <= s1_off_q;
      s2_ra_q  <= s1_ra_q;
      s2_rb_q  <= s1_rb_q;
      s2_rd2_q <= s1_rdif_q * s1_rdif_q;
      s2_rs2_q <= s1_rsum_q * s1_rsum_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Squared distance, containment and overlap tests.
  logic           s3_v_q;
  logic [D2W-1:0] s3_dist2_q;
  root_side_t     s3_side_q;
  logic [D2W-1:0] s3_dist2_d;

  assign s3_dist2_d = s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_dist2_q        <= s3_dist2_d;
      s3_side_q.ca      <= s2_ca_q;
      s3_side_q.off     <= s2_off_q;
      s3_side_q.ra      <= s2_ra_q;
      s3_side_q.rb      <= s2_rb_q;
      s3_side_q.contain <= (s3_dist2_d <= D2W'(s2_rd2_q));
      s3_side_q.ovl     <= (D2W'(s2_rs2_q) > s3_dist2_d);
    end
  end

  // ---------------------------------------------------------- square root
  bsm_ctl_t   sq_ctl;
  logic       sq_vld;
  logic [QW-1:0] sq_root;
  root_side_t sq_side;

  assign sq_ctl.en  = en;
  assign sq_ctl.vld = s3_v_q;

  bsm_sqrt #(
    .W      (QW),
    .SIDE_W (RSW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sq_ctl),
    .rad_i  (s3_dist2_q),
    .side_i (s3_side_q),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // ---------------------------------------------------------------- stage 4
  // Merged radius, saturation, and the step length R - ra.
  logic [C+1:0]  s4_sum;
  logic [QW-1:0] s4_rfull;
  logic          s4_big;

  logic               s4_v_q;
  logic [2:0][C-1:0]  s4_ca_q;
  logic [2:0][C:0]    s4_off_q;
  logic [2:0][QW-1:0] s4_mag_q;
  logic [RW-1:0]      s4_ra_q, s4_rout_q;
  logic [QW-1:0]      s4_d_q, s4_rstep_q;
  logic               s4_contain_q, s4_pick_a_q, s4_ovl_q, s4_sat_q;

  assign s4_sum   = (C+2)'(sq_root) + (C+2)'(sq_side.ra) + (C+2)'(sq_side.rb);
  assign s4_rfull = s4_sum[C+1:1];
  assign s4_big   = (s4_rfull[C:C-1] != 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= sq_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_mag_q[i] <= sq_side.off[i][C] ? (QW'(0) - sq_side.off[i]) : sq_side.off[i];
      end
      s4_ca_q      <= sq_side.ca;
      s4_off_q     <= sq_side.off;
      s4_ra_q      <= sq_side.ra;
      s4_d_q       <= sq_root;
      s4_rstep_q   <= s4_rfull - QW'(sq_side.ra);
      s4_contain_q <= sq_side.contain;
      s4_pick_a_q  <= (sq_side.ra > sq_side.rb);
      s4_ovl_q     <= sq_side.ovl;
      s4_sat_q     <= !sq_side.contain && s4_big;
      if (sq_side.contain) begin
        s4_rout_q <= (sq_side.ra > sq_side.rb) ? sq_side.ra : sq_side.rb;
      end else if (s4_big) begin
        s4_rout_q <= '1;
      end else begin
        s4_rout_q <= s4_rfull[RW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Step numerators |off| * (R - ra) and the two growth squares.
  logic                s5_v_q;
  logic [2:0][D2W-1:0] s5_num_q;
  logic [QW-1:0]       s5_d_q;
  div_side_t           s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en) s5_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s5_num_q[i] <= s4_mag_q[i] * s4_rstep_q;
      s5_d_q            <= s4_d_q;
      s5_side_q.ca      <= s4_ca_q;
      s5_side_q.off     <= s4_off_q;
      s5_side_q.rout    <= s4_rout_q;
      s5_side_q.rout2   <= s4_rout_q * s4_rout_q;
      s5_side_q.ra2     <= s4_ra_q * s4_ra_q;
      s5_side_q.contain <= s4_contain_q;
      s5_side_q.pick_a  <= s4_pick_a_q;
      s5_side_q.ovl     <= s4_ovl_q;
      s5_side_q.sat     <= s4_sat_q;
    end
  end

  // -------------------------------------------------------------- divider
  // The divisor is zero only for equal centers, which are always contained,
  // so the quotient is ignored in that case.
  bsm_ctl_t           dv_ctl;
  logic               dv_vld;
  logic [2:0][QW-1:0] dv_quo;
  div_side_t          dv_side;

  assign dv_ctl.en  = en;
  assign dv_ctl.vld = s5_v_q;

  bsm_div #(
    .QW     (QW),
    .SIDE_W (DSW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dv_ctl),
    .num_i  (s5_num_q),
    .den_i  (s5_d_q),
    .side_i (s5_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  // --------------------------------------------------------- output stage
  // Apply the signed step to center a, or pick a whole sphere on containment.
  logic [2:0][C-1:0] mc_d, mc_q;
  logic [C:0]        ca_ext;
  logic [RW-1:0]     rout_q;
  logic [GW-1:0]     growth_q;
  logic              ovl_q, sat_q;

  always_comb begin
    ca_ext = '0;
    for (int i = 0; i < 3; i++) begin
      ca_ext = {dv_side.ca[i][C-1], dv_side.ca[i]};
      if (dv_side.contain) begin
        mc_d[i] = dv_side.pick_a ? dv_side.ca[i] : C'(ca_ext + dv_side.off[i]);
      end else if (dv_side.off[i][C]) begin
        mc_d[i] = C'(ca_ext - dv_quo[i]);
      end else begin
        mc_d[i] = C'(ca_ext + dv_quo[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= dv_vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mc_q     <= mc_d;
      rout_q   <= dv_side.rout;
      growth_q <= dv_side.rout2 - dv_side.ra2;
      ovl_q    <= dv_side.ovl;
      sat_q    <= dv_side.sat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign merged_x_o      = mc_q[0];
  assign merged_y_o      = mc_q[1];
  assign merged_z_o      = mc_q[2];
  assign merged_radius_o = rout_q;
  assign growth_o        = growth_q;
  assign overlap_o       = ovl_q;
  assign saturated_o     = sat_q;

endmodule

`default_nettype wire

@@ rtl/core/bsm_checker.sv @@
// Port-level checks for bounding_sphere_merge_top, attached by bind.
// Depends on bsm_pkg only through the top level it watches.
`default_nettype none

module bsm_checker #(
  parameter int unsigned COORD_BITS = 24
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic signed [COORD_BITS-1:0] a_center_x_i,
  input logic signed [COORD_BITS-1:0] a_center_y_i,
  input logic signed [COORD_BITS-1:0] a_center_z_i,
  input logic [COORD_BITS-2:0]        a_radius_i,
  input logic signed [COORD_BITS-1:0] b_center_x_i,
  input logic signed [COORD_BITS-1:0] b_center_y_i,
  input logic signed [COORD_BITS-1:0] b_center_z_i,
  input logic [COORD_BITS-2:0]        b_radius_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [COORD_BITS-1:0] merged_x_o,
  input logic signed [COORD_BITS-1:0] merged_y_o,
  input logic signed [COORD_BITS-1:0] merged_z_o,
  input logic [COORD_BITS-2:0]        merged_radius_o,
  input logic [2*COORD_BITS-3:0]      growth_o,
  input logic                        overlap_o,
  input logic                        saturated_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(merged_radius_o)
      && $stable(growth_o) && $stable(merged_x_o) && $stable(merged_y_o)
      && $stable(merged_z_o) && $stable(overlap_o) && $stable(saturated_o))
    else $error("stalled result changed");

  // Hold a stalled input transfer.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i
      && $stable({a_center_x_i, a_center_y_i, a_center_z_i, a_radius_i,
                  b_center_x_i, b_center_y_i, b_center_z_i, b_radius_i}))
    else $error("stalled input changed");

  // Back-pressure only while a result is held.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without a held result");

  // A saturated radius reads as the maximum code.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (&merged_radius_o))
    else $error("saturated radius not at maximum");

  // No result shows as reset is released.
  a_rst_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result after reset");

endmodule

bind bounding_sphere_merge_top bsm_checker #(.COORD_BITS(COORD_BITS)) u_bsm_checker (.*);

`default_nettype wire

@@ bench/tb_bounding_sphere_merge_top.sv @@
// Testbench for bounding_sphere_merge_top: streams sphere pairs through the
// pipeline and checks every merged sphere against an in-bench predictor.
// Depends on bsm_pkg and the bounding_sphere_merge_top RTL only.
`timescale 1ns / 100ps

module tb_bounding_sphere_merge_top;
  import bsm_pkg::*;

  localparam int CB = 24;           // coordinate width
  localparam int RB = CB - 1;       // radius width
  localparam int GB = 2 * (CB - 1); // growth width
  localparam int NUM_RANDOM = 1700;
  localparam int DRAIN_CYCLES = 2 * CB + 20;
  localparam int LONG_HOLD = 400;
  localparam logic [RB-1:0] RMAX = {RB{1'b1}};
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  typedef struct packed {
    logic signed [CB-1:0] ax, ay, az;
    logic [RB-1:0]        ar;
    logic signed [CB-1:0] bx, by, bz;
    logic [RB-1:0]        br;
  } sphere_pair_t;

  typedef struct packed {
    logic signed [CB-1:0] x, y, z;
    logic [RB-1:0]        r;
    logic [GB-1:0]        growth;
    logic                 ovl;
    logic                 sat;
  } merged_sphere_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  sphere_pair_t pair_drv = '0;

  logic                 in_stall, out_valid;
  logic signed [CB-1:0] mx, my, mz;
  logic [RB-1:0]        mr;
  logic [GB-1:0]        mgrowth;
  logic                 movl, msat;

  bounding_sphere_merge_top #(.COORD_BITS(CB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .a_center_x_i(pair_drv.ax), .a_center_y_i(pair_drv.ay),
    .a_center_z_i(pair_drv.az), .a_radius_i(pair_drv.ar),
    .b_center_x_i(pair_drv.bx), .b_center_y_i(pair_drv.by),
    .b_center_z_i(pair_drv.bz), .b_radius_i(pair_drv.br),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .merged_x_o(mx), .merged_y_o(my), .merged_z_o(mz),
    .merged_radius_o(mr), .growth_o(mgrowth),
    .overlap_o(movl), .saturated_o(msat)
  );

  always #5 clk_i = ~clk_i;

  sphere_pair_t   pair_queue[$];     // pairs still to be offered
  merged_sphere_t pending_merges[$]; // merged spheres the pipeline still owes
  int  mismatches = 0;
  int  merges_seen = 0;
  int  contained_cnt = 0, overlap_cnt = 0, sat_cnt = 0;
  bit  stimulus_done = 1'b0;
  bit  long_hold = 1'b0;
  bit  in_taken = 1'b0;

  // Floor square root; the squared distance stays below 2^54.
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root, cand;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  // Smallest sphere enclosing both spheres of the pair, plus growth and flags.
  function automatic merged_sphere_t predict_merge(sphere_pair_t p);
    merged_sphere_t m;
    longint ca[3], off[3], mc[3];
    logic [63:0] ra, rb, dist2, rdiff2, root_dist, rfull, rout, stepv, mag, grow;
    longint rdiff;
    ca[0] = p.ax; ca[1] = p.ay; ca[2] = p.az;
    off[0] = longint'(p.bx) - ca[0];
    off[1] = longint'(p.by) - ca[1];
    off[2] = longint'(p.bz) - ca[2];
    ra = p.ar;
    rb = p.br;
    m.sat = 1'b0;
    dist2 = '0;
    for (int i = 0; i < 3; i++) dist2 += off[i] * off[i];
    rdiff = longint'(rb) - longint'(ra);
    rdiff2 = rdiff * rdiff;
    if (dist2 <= rdiff2) begin
      // one sphere holds the other; b wins a tie
      for (int i = 0; i < 3; i++) mc[i] = (ra > rb) ? ca[i] : ca[i] + off[i];
      rout = (ra > rb) ? ra : rb;
    end else begin
      root_dist = floor_sqrt(dist2);
      rfull = (root_dist + ra + rb) >> 1;
      // center moves with the unclamped radius
      for (int i = 0; i < 3; i++) begin
        mag = (off[i] < 0) ? -off[i] : off[i];
        stepv = (mag * (rfull - ra)) / root_dist;
        mc[i] = (off[i] < 0) ? ca[i] - longint'(stepv) : ca[i] + longint'(stepv);
      end
      if (rfull > RMAX) begin
        rout = RMAX;
        m.sat = 1'b1;
      end else begin
        rout = rfull;
      end
    end
    m.x = mc[0][CB-1:0];
    m.y = mc[1][CB-1:0];
    m.z = mc[2][CB-1:0];
    m.r = rout[RB-1:0];
    grow = rout * rout - ra * ra;
    m.growth = grow[GB-1:0];
    m.ovl = ((ra + rb) * (ra + rb)) > dist2;
    return m;
  endfunction

  task automatic add_pair(input logic signed [CB-1:0] ax, ay, az, input logic [RB-1:0] ar,
                          input logic signed [CB-1:0] bx, by, bz, input logic [RB-1:0] br);
    sphere_pair_t p;
    p = '{ax, ay, az, ar, bx, by, bz, br};
    pair_queue.push_back(p);
  endtask

  function automatic logic signed [CB-1:0] near_coord(logic signed [CB-1:0] base, int span);
    return base + CB'($signed($urandom_range(2 * span)) - span);
  endfunction

  // Fill the pair queue: directed corners first, then random pairs.
  initial begin
    sphere_pair_t p;
    int kind;
    logic [191:0] rnd;
    // equal centers, equal radii: b wins the tie
    add_pair(100, 200, 300, 500, 100, 200, 300, 500);
    // equal centers, a larger / b larger
    add_pair(-50, 0, 7, 900, -50, 0, 7, 10);
    add_pair(-50, 0, 7, 10, -50, 0, 7, 900);
    // zero radii, coincident points
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    // zero radii, distinct points
    add_pair(0, 0, 0, 0, 1000, -2000, 3000, 0);
    // containment exactly on the boundary (distance 50, radius gap 50)
    add_pair(0, 0, 0, 100, 30, 40, 0, 150);
    add_pair(0, 0, 0, 150, 30, 40, 0, 100);
    // touching spheres: not a strict overlap
    add_pair(0, 0, 0, 100, 300, 400, 0, 400);
    // overlapping and separated pairs
    add_pair(10, 20, 30, 1000, 500, -600, 700, 800);
    add_pair(-7000, 3000, 12, 5, 9000, -4000, 55, 7);
    // coordinate extremes with maximum or zero radii: radius saturates
    add_pair(CMIN, CMIN, CMIN, RMAX, CMAX, CMAX, CMAX, RMAX);
    add_pair(CMAX, CMIN, CMAX, RMAX, CMIN, CMAX, CMIN, 0);
    add_pair(CMAX, CMAX, CMAX, 0, CMIN, CMIN, CMIN, 0);
    add_pair(CMIN, 0, 0, RMAX, CMAX, 0, 0, RMAX);
    // maximum radius that holds the other sphere
    add_pair(CMAX, CMAX, CMAX, RMAX, CMAX - 1'b1, CMAX, CMAX, 1);
    add_pair(CMIN, CMIN, CMIN, 1, CMIN, CMIN, CMIN + 1'b1, RMAX);
    // one axis only, negative step direction
    add_pair(5000, 0, 0, 300, -5000, 0, 0, 200);
    add_pair(0, 0, 5000, 0, 0, 0, -5000, RMAX);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        // any values the fields allow
        rnd = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        p = rnd[$bits(sphere_pair_t)-1:0];
      end else if (kind < 75) begin
        // nearby spheres: real merges with meaningful center steps
        p.ax = CB'($urandom()); p.ay = CB'($urandom()); p.az = CB'($urandom());
        p.bx = near_coord(p.ax, 20000);
        p.by = near_coord(p.ay, 20000);
        p.bz = near_coord(p.az, 20000);
        p.ar = RB'($urandom_range(30000));
        p.br = RB'($urandom_range(30000));
      end else begin
        // one sphere swallows the other
        p.ax = CB'($urandom()); p.ay = CB'($urandom()); p.az = CB'($urandom());
        p.bx = near_coord(p.ax, 300);
        p.by = near_coord(p.ay, 300);
        p.bz = near_coord(p.az, 300);
        p.ar = RB'($urandom_range(RMAX));
        p.br = $urandom_range(1) ? RB'($urandom_range(600)) : RB'($urandom_range(RMAX));
      end
      pair_queue.push_back(p);
    end
  end

  // Reset once, then release.
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: offer pairs in bursts, hold the payload while stalled.
  int burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1) ? $urandom_range(80, 1) : $urandom_range(6, 1);
        gap_left = $urandom_range(3) == 0 ? 0 : $urandom_range(7);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pair_queue.size() > 0) begin
        pair_drv <= pair_queue.pop_front();
        in_valid <= 1'b1;
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        stimulus_done = 1'b1;
      end
    end
  end

  // Receiver: step through four stall patterns in turn.
  int stall_cycle = 0;
  always @(negedge clk_i) begin
    int mode;
    mode = (stall_cycle / 250) % 4;
    stall_cycle++;
    case (mode)
      0: out_stall <= long_hold;
      1: out_stall <= long_hold | ($urandom_range(9) < 3);
      2: out_stall <= long_hold | stall_cycle[0];
      default: out_stall <= long_hold | ($urandom_range(9) < 8);
    endcase
  end

  // Long hold-off: let the pipeline fill up and push back on the sender.
  initial begin
    repeat (600) @(posedge clk_i);
    long_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    long_hold = 1'b0;
  end

  // Monitor: predict on each input transfer, check on each output transfer.
  always @(posedge clk_i) begin
    merged_sphere_t want, got;
    in_taken <= in_valid && !in_stall;
    if (rst_ni && in_valid && !in_stall) begin
      want = predict_merge(pair_drv);
      pending_merges.push_back(want);
      if (want.ovl) overlap_cnt++;
      if (want.sat) sat_cnt++;
      if ((longint'(pair_drv.br) - longint'(pair_drv.ar)) ** 2 >=
          (longint'(pair_drv.bx) - pair_drv.ax) ** 2 +
          (longint'(pair_drv.by) - pair_drv.ay) ** 2 +
          (longint'(pair_drv.bz) - pair_drv.az) ** 2) contained_cnt++;
    end
    if (rst_ni && out_valid && !out_stall) begin
      got = '{mx, my, mz, mr, mgrowth, movl, msat};
      merges_seen++;
      if (pending_merges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected merged sphere %p", got);
      end else begin
        want = pending_merges.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("merge %0d mismatch\n  expected %p\n  actual   %p", merges_seen, want, got);
        end
      end
    end
  end

  // End of run: drain, settle, report.
  initial begin
    wait (stimulus_done && pending_merges.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_merges.size() != 0) mismatches++;
    $display("merged %0d sphere pairs: %0d contained, %0d overlapping, %0d saturated",
             merges_seen, contained_cnt, overlap_cnt, sat_cnt);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("timeout with %0d merges outstanding", pending_merges.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
